// File: src/exec_mask_scalar_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the exec-mask scalar unit
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef EXEC_MASK_SCALAR_UNIT_MACROS_SVH
`define EXEC_MASK_SCALAR_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// property checked while reset is released
`define ESU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked during reset as well
`define ESU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ESU_ASSERT(lbl, clk, rst_n, prop, msg)
`define ESU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: src/esu_pkg.sv
// ----------------------------------------------------------------------------
// esu_pkg
// Types, codes and helper functions of the exec-mask scalar unit.
// ----------------------------------------------------------------------------
package esu_pkg;

  localparam int unsigned DATA_W      = 64;
  localparam int unsigned HALF_W      = 32;
  localparam int unsigned NIBBLES     = 8;   // nibbles per 32-bit half
  localparam int unsigned MODE_W      = 4;
  localparam int unsigned IN_TDATA_W  = 72;  // 69 bits of fields, byte padded
  localparam int unsigned OUT_TDATA_W = 136; // 131 bits of fields, byte padded
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;

  // register word index (paddr[2])
  localparam logic REG_WAVE64_MODE = 1'b0;

  typedef enum logic [MODE_W-1:0] {
    MODE_AND      = 4'd0,
    MODE_NAND     = 4'd1,
    MODE_ANDN1    = 4'd2,
    MODE_ANDN2    = 4'd3,
    MODE_OR       = 4'd4,
    MODE_ORN1     = 4'd5,
    MODE_NOR      = 4'd6,
    MODE_XOR      = 4'd7,
    MODE_XNOR     = 4'd8,
    MODE_ORN2     = 4'd9,
    MODE_WQM      = 4'd10,
    MODE_QUADMASK = 4'd11
  } esu_mode_e;

  typedef struct packed {
    logic [DATA_W-1:0] dest_value;
    logic              dest_high_written;
    logic              scc_out;
    logic              scc_written;
    logic [DATA_W-1:0] exec_now;
  } esu_result_t;

  // each nonzero nibble becomes all ones
  function automatic logic [HALF_W-1:0] wqm32(input logic [HALF_W-1:0] v);
    logic [HALF_W-1:0] r;
    r = '0;
    for (int i = 0; i < NIBBLES; i++) begin
      r[i*4 +: 4] = {4{|v[i*4 +: 4]}};
    end
    return r;
  endfunction

  // one bit per nibble, set when the nibble is nonzero
  function automatic logic [NIBBLES-1:0] qmask32(input logic [HALF_W-1:0] v);
    logic [NIBBLES-1:0] r;
    r = '0;
    for (int i = 0; i < NIBBLES; i++) begin
      r[i] = |v[i*4 +: 4];
    end
    return r;
  endfunction

endpackage

// File: src/esu_compute.sv
// ----------------------------------------------------------------------------
// esu_compute
// Combinational datapath: saveexec combine, wqm, quadmask, SCC and new mask.
// ----------------------------------------------------------------------------
module esu_compute (
  input  logic [esu_pkg::MODE_W-1:0] mode_i,
  input  logic                       wide_op_i,
  input  logic [esu_pkg::DATA_W-1:0] src_word_i,
  input  logic [esu_pkg::DATA_W-1:0] exec_i,
  input  logic                       wave64_i,
  output esu_pkg::esu_result_t       result_o
);
  import esu_pkg::*;

  logic [DATA_W-1:0] comb_val;
  logic [HALF_W-1:0] src_lo;
  logic [HALF_W-1:0] src_hi;

  assign src_lo = src_word_i[HALF_W-1:0];
  assign src_hi = src_word_i[DATA_W-1:HALF_W];

  // bitwise combine over the full word; the 32-bit form uses the low half only
  always_comb begin
    case (esu_mode_e'(mode_i))
      MODE_AND:   comb_val = exec_i & src_word_i;
      MODE_NAND:  comb_val = ~(exec_i & src_word_i);
      MODE_ANDN1: comb_val = exec_i & ~src_word_i;
      MODE_ANDN2: comb_val = ~exec_i & src_word_i;
      MODE_OR:    comb_val = exec_i | src_word_i;
      MODE_ORN1:  comb_val = exec_i | ~src_word_i;
      MODE_NOR:   comb_val = ~(exec_i | src_word_i);
      MODE_XOR:   comb_val = exec_i ^ src_word_i;
      MODE_XNOR:  comb_val = ~(exec_i ^ src_word_i);
      default:    comb_val = ~exec_i | src_word_i;
    endcase
  end

  always_comb begin
    result_o = '0;
    result_o.exec_now = exec_i;
    if (mode_i inside {[MODE_AND:MODE_ORN2]}) begin
      result_o.scc_written = 1'b1;
      if (wide_op_i) begin
        result_o.dest_value        = exec_i;
        result_o.dest_high_written = 1'b1;
        result_o.exec_now          = comb_val;
        result_o.scc_out           = wave64_i ? (|comb_val) : (|comb_val[HALF_W-1:0]);
      end else begin
        result_o.dest_value = {{HALF_W{1'b0}}, exec_i[HALF_W-1:0]};
        result_o.exec_now   = {(wave64_i ? exec_i[DATA_W-1:HALF_W] : {HALF_W{1'b0}}),
                               comb_val[HALF_W-1:0]};
        result_o.scc_out    = |comb_val[HALF_W-1:0];
      end
    end else if (mode_i == MODE_WQM) begin
      result_o.dest_value        = {(wide_op_i ? wqm32(src_hi) : {HALF_W{1'b0}}),
                                    wqm32(src_lo)};
      result_o.dest_high_written = wide_op_i;
    end else if (mode_i == MODE_QUADMASK) begin
      result_o.dest_value        = {{(DATA_W-2*NIBBLES){1'b0}},
                                    (wide_op_i ? qmask32(src_hi) : {NIBBLES{1'b0}}),
                                    qmask32(src_lo)};
      result_o.dest_high_written = wide_op_i;
    end
  end

endmodule

// File: src/exec_mask_scalar_unit.sv
// ----------------------------------------------------------------------------
// exec_mask_scalar_unit
// Scalar execution-mask unit of one GPU wave (saveexec, wqm, quadmask).
// ----------------------------------------------------------------------------
// Usage:
//   Operations arrive on the s_axis stream; each transfer carries the
//   operation code, the 32/64-bit form flag and the 64-bit source. Every
//   operation yields exactly one result transfer on m_axis: destination
//   value, destination-high flag, SCC and its write flag, and the mask as
//   it stands after the operation.
//   The input register loads at the input transfer edge and the result
//   register loads when the item advances, which a stalled receiver can
//   hold off; m_axis_tvalid rises once the result register is loaded.
//   Throughput is one operation per cycle while the receiver does not stall;
//   the mask register is loaded from the datapath as each operation advances,
//   so back-to-back operations see each other's updates.
//   When the receiver stalls, the result register holds and the input
//   register fills; s_axis_tready drops only once both are occupied.
//   The APB port holds wave64_mode at address 0 (bit 0); write it only while
//   the unit is idle. Reset clears both stages, sets the mask to all ones
//   and selects 64-lane waves.
// ----------------------------------------------------------------------------
`include "exec_mask_scalar_unit_macros.svh"

module exec_mask_scalar_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // s_axis_tdata: mode[3:0], wide_op[4], src_word[68:5], zero pad
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [esu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // m_axis_tdata: dest_value[63:0], dest_high_written[64], scc_out[65],
  //               scc_written[66], exec_now[130:67], zero pad
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [esu_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // APB configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [esu_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [esu_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [esu_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import esu_pkg::*;

  // configuration
  logic wave64_q, wave64_d;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_WAVE64_MODE);
  assign wave64_d = cfg_wr ? pwdata[0] : wave64_q;
  assign prdata = (paddr[2] == REG_WAVE64_MODE) ? {{(APB_DATA_W-1){1'b0}}, wave64_q} : '0;

  // input register
  logic              in_valid_q, in_valid_d;
  logic [MODE_W-1:0] mode_q, mode_d;
  logic              wide_q, wide_d;
  logic [DATA_W-1:0] src_q, src_d;
  logic              in_xfer;
  logic              advance;

  // result register and mask
  logic              out_valid_q, out_valid_d;
  esu_result_t       out_res_q, out_res_d;
  logic [DATA_W-1:0] exec_q, exec_d;
  esu_result_t       res;

  // an item leaves the input register when the result register is free or drains
  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign in_xfer       = s_axis_tvalid & s_axis_tready;

  always_comb begin
    in_valid_d = in_xfer | (in_valid_q & ~advance);
    mode_d     = in_xfer ? s_axis_tdata[MODE_W-1:0] : mode_q;
    wide_d     = in_xfer ? s_axis_tdata[MODE_W] : wide_q;
    src_d      = in_xfer ? s_axis_tdata[MODE_W+1 +: DATA_W] : src_q;
  end

  esu_compute u_compute (
    .mode_i     (mode_q),
    .wide_op_i  (wide_q),
    .src_word_i (src_q),
    .exec_i     (exec_q),
    .wave64_i   (wave64_q),
    .result_o   (res)
  );

  always_comb begin
    out_valid_d = advance | (out_valid_q & ~m_axis_tready);
    out_res_d   = advance ? res : out_res_q;
    exec_d      = advance ? res.exec_now : exec_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      exec_q      <= '1;
      wave64_q    <= 1'b1;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      exec_q      <= exec_d;
      wave64_q    <= wave64_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    wide_q    <= wide_d;
    src_q     <= src_d;
    out_res_q <= out_res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-2*DATA_W-3){1'b0}},
                          out_res_q.exec_now,
                          out_res_q.scc_written,
                          out_res_q.scc_out,
                          out_res_q.dest_high_written,
                          out_res_q.dest_value};

  // assertions
  `ESU_ASSERT(a_exec_only_on_advance, clk_i, rst_ni,
              !advance |=> $stable(exec_q), "exec mask changed without an operation")
  `ESU_ASSERT(a_result_tracks_exec, clk_i, rst_ni,
              out_valid_q |-> (out_res_q.exec_now == exec_q),
              "pending result disagrees with exec mask")
  `ESU_ASSERT(a_scc_needs_write, clk_i, rst_ni,
              out_valid_q && out_res_q.scc_out |-> out_res_q.scc_written,
              "SCC set on an operation that does not write it")
  // stages are empty on the edge after any cycle spent in reset
  `ESU_ASSERT_ALWAYS(a_no_advance_in_reset, clk_i,
                     !rst_ni |=> !out_valid_q && !in_valid_q, "pipeline occupied during reset")

endmodule
